@@ rtl/bbl_pkg.sv @@
// shared types and constants of the edge clamped box blur line unit
package bbl_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int NORM_BITS   = 17;
  localparam int NORM_FRAC   = 16;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] red_in;
    logic [SAMPLE_BITS-1:0] green_in;
    logic [SAMPLE_BITS-1:0] blue_in;
    logic                   last_in_line;
  } pixel_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] red_out;
    logic [SAMPLE_BITS-1:0] green_out;
    logic [SAMPLE_BITS-1:0] blue_out;
    logic                   run_last;
    logic                   line_end;
  } result_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] red;
    logic [SAMPLE_BITS-1:0] green;
    logic [SAMPLE_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t pix;
    logic first;
    logic last;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACC,
    BK_DRAIN,
    BK_MUL,
    BK_OUT
  } back_state_t;

endpackage

@@ rtl/bbl_ram.sv @@
// generic single write port ram with registered read
module bbl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bbl_fifo.sv @@
// small register queue used between the parts of the blur unit
module bbl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers differ while empty");

endmodule

@@ rtl/bbl_front.sv @@
// front part: takes pixel words, tracks line position and queues jobs
module bbl_front
  import bbl_pkg::*;
#(
  parameter int MAX_RADIUS = 15
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [3:0]                       radius,
  input  logic                             push,
  input  pixel_in_t                        pixel,
  output logic                             full,
  output logic                             job_valid,
  input  logic                             job_pop,
  output job_t                             job,
  output logic [$clog2(MAX_RADIUS+1)-1:0]  job_r,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0] job_n
);

  localparam int HIST = 2 * MAX_RADIUS + 1;
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int NW   = $clog2(HIST);
  localparam int SW   = $clog2(HIST + 1);
  localparam int JW   = $bits(job_t) + RW + NW;

  logic [SW-1:0] seen;
  logic [SW-1:0] seen_next;
  logic          accept;
  logic [RW-1:0] r_sat;
  logic [NW-1:0] n_cur;
  job_t          job_in;
  logic [JW-1:0] q_din;
  logic [JW-1:0] q_dout;
  logic          q_empty;

  assign accept = push && !full;
  assign r_sat  = (32'(radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius);
  assign n_cur  = (seen < SW'(HIST)) ? NW'(seen) : NW'(HIST - 1);

  always_comb begin
    job_in.pix.red   = pixel.red_in;
    job_in.pix.green = pixel.green_in;
    job_in.pix.blue  = pixel.blue_in;
    job_in.first     = (seen == '0);
    job_in.last      = pixel.last_in_line;
    q_din            = {job_in, r_sat, n_cur};
  end

  always_comb begin
    seen_next = seen;
    if (accept) begin
      if (pixel.last_in_line) begin
        seen_next = '0;
      end else if (seen < SW'(HIST)) begin
        seen_next = seen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else begin
      seen <= seen_next;
    end
  end

  bbl_fifo #(
    .WIDTH (JW),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .full  (full),
    .pop   (job_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign job_valid = !q_empty;
  assign {job, job_r, job_n} = q_dout;

  assert property (@(posedge clk) disable iff (rst) seen <= SW'(HIST))
    else $error("line position above window length");
  assert property (@(posedge clk) disable iff (rst)
    (accept && pixel.last_in_line) |=> seen == '0)
    else $error("line position not cleared after last word");
  assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job_r <= RW'(MAX_RADIUS))
    else $error("queued radius above limit");

endmodule

@@ rtl/bbl_back.sv @@
// back part: pixel history, window sums, scaling and result queue
module bbl_back
  import bbl_pkg::*;
#(
  parameter int MAX_RADIUS = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  output logic                              job_pop,
  input  job_t                              job,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]   job_r,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0] job_n,
  input  logic                              pop,
  output logic                              empty,
  output result_t                           result
);

  localparam int HIST  = 2 * MAX_RADIUS + 1;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int NW    = $clog2(HIST);
  localparam int KW    = NW + 2;
  localparam int SUM_W = SAMPLE_BITS + NW;
  localparam int PW    = SUM_W + NORM_BITS;
  localparam int RND   = 1 << (NORM_FRAC - 1);

  back_state_t state;
  back_state_t state_next;

  logic [NORM_BITS-1:0] norm_tab [MAX_RADIUS+1];

  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_norm
    localparam int Wd      = 2 * g + 1;
    localparam int NormVal = ((1 << NORM_FRAC) + Wd / 2) / Wd;
    assign norm_tab[g] = NORM_BITS'(NormVal);
  end

  logic [NW-1:0]        wp;
  logic [NW-1:0]        newest;
  rgb_t                 first_pix;
  logic [RW-1:0]        r_q;
  logic [NW-1:0]        n_q;
  logic                 last_q;
  logic [RW-1:0]        lag;
  logic [NW-1:0]        j;
  logic                 rd_vld;
  logic                 rd_first;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     sum_g;
  logic [SUM_W-1:0]     sum_b;
  logic [PW-1:0]        prod_r;
  logic [PW-1:0]        prod_g;
  logic [PW-1:0]        prod_b;

  logic                 hist_we;
  logic                 issue;
  logic                 res_push;
  logic                 res_full;
  logic                 step_done;
  logic                 emit_any;
  logic [RW-1:0]        lag_start;
  logic signed [KW-1:0] k;
  logic                 k_neg;
  logic                 k_first;
  logic [NW:0]          dif;
  logic [NW-1:0]        raddr;
  rgb_t                 rdata;
  rgb_t                 add_pix;
  result_t              res_in;

  function automatic logic [SAMPLE_BITS-1:0] scale(input logic [PW-1:0] p);
    logic [PW:0]             t;
    logic [PW-NORM_FRAC:0]   m;
    t = {1'b0, p} + (PW + 1)'(RND);
    m = t[PW:NORM_FRAC];
    if (m > (PW - NORM_FRAC + 1)'({SAMPLE_BITS{1'b1}})) begin
      scale = '1;
    end else begin
      scale = m[SAMPLE_BITS-1:0];
    end
  endfunction

  // window tap position, newest pixel at zero
  always_comb begin
    k       = $signed(KW'(lag) + KW'(r_q) - KW'(j));
    k_neg   = k[KW-1];
    k_first = !k_neg && (k > $signed(KW'(n_q)));
    dif     = {1'b0, newest} - k[NW:0];
    if (k_neg) begin
      raddr = newest;
    end else if (dif[NW]) begin
      raddr = NW'(dif + (NW + 1)'(HIST));
    end else begin
      raddr = dif[NW-1:0];
    end
  end

  assign step_done = (j == NW'({r_q, 1'b0}));
  assign emit_any  = job.last || (job_n >= NW'(job_r));
  assign lag_start = (job.last && (job_n < NW'(job_r))) ? RW'(job_n) : job_r;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_valid && emit_any) begin
          state_next = BK_ACC;
        end
      end
      BK_ACC: begin
        if (step_done) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        state_next = BK_MUL;
      end
      BK_MUL: begin
        state_next = BK_OUT;
      end
      BK_OUT: begin
        if (!res_full) begin
          state_next = (!last_q || lag == '0) ? BK_IDLE : BK_ACC;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    job_pop  = 1'b0;
    issue    = 1'b0;
    res_push = 1'b0;
    unique case (state)
      BK_IDLE:  job_pop  = job_valid;
      BK_ACC:   issue    = 1'b1;
      BK_DRAIN: ;
      BK_MUL:   ;
      BK_OUT:   res_push = 1'b1;
      default:  ;
    endcase
  end

  assign hist_we = job_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      wp     <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (hist_we) begin
        wp <= (wp == NW'(HIST - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

  assign add_pix = rd_first ? first_pix : rdata;

  always_ff @(posedge clk) begin
    rd_first <= k_first;
    if (hist_we) begin
      newest <= wp;
      r_q    <= job_r;
      n_q    <= job_n;
      last_q <= job.last;
      lag    <= lag_start;
      if (job.first) begin
        first_pix <= job.pix;
      end
    end
    if (issue) begin
      j <= j + 1'b1;
    end
    if (rd_vld) begin
      sum_r <= sum_r + SUM_W'(add_pix.red);
      sum_g <= sum_g + SUM_W'(add_pix.green);
      sum_b <= sum_b + SUM_W'(add_pix.blue);
    end
    if (state == BK_MUL) begin
      prod_r <= PW'(sum_r * norm_tab[r_q]);
      prod_g <= PW'(sum_g * norm_tab[r_q]);
      prod_b <= PW'(sum_b * norm_tab[r_q]);
    end
    if (state_next == BK_ACC && state != BK_ACC) begin
      j     <= '0;
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end
    if (state == BK_OUT && !res_full && last_q && lag != '0) begin
      lag <= lag - 1'b1;
    end
  end

  bbl_ram #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (HIST)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp),
    .wdata (job.pix),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    res_in.red_out   = scale(prod_r);
    res_in.green_out = scale(prod_g);
    res_in.blue_out  = scale(prod_b);
    res_in.run_last  = !last_q || (lag == '0);
    res_in.line_end  = last_q && (lag == '0);
  end

  bbl_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

  assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == BK_ACC)
    else $error("history read without a window step");
  assert property (@(posedge clk) disable iff (rst)
    (state == BK_OUT && !res_full) |=> (state == BK_IDLE || state == BK_ACC))
    else $error("result word written without moving on");
  assert property (@(posedge clk) disable iff (rst)
    state == BK_ACC |-> j <= NW'({r_q, 1'b0}))
    else $error("window step past its end");
  assert property (@(posedge clk) disable iff (rst)
    state != BK_IDLE |-> lag <= r_q)
    else $error("output lag beyond radius");

endmodule

@@ rtl/edge_clamped_box_blur_line_unit.sv @@
// top level of the edge clamped box blur line unit
//
// pixel words enter on push/full: a word is taken at a clock edge with push
// high and full low. blurred words leave on empty/pop: the oldest word sits on
// result while empty is low and is taken at an edge with pop high.
// radius is written on cfg_valid/cfg_ready (ready is always high); the user
// must write it only while the unit is idle, the unit does not enforce this.
// it resets to 4 and is limited to MAX_RADIUS. a word whose window is
// complete gives one blurred word; a word marked last_in_line flushes the
// remaining words of the line, the final one with line_end set. run_last
// marks the last word caused by an input word. the back part picks up each
// input word in its idle state, then for each blurred word steps window tap
// by tap through the history ram read port, then drains, multiplies and
// writes; it takes no new input word until those of the current one are out.
// input words queue two deep ahead of the back part, results two deep after
// it; a stalled receiver fills the result queue, then the back part and the
// input queue hold and full rises.
// reset clears the line position, queues and control; the history ram is not
// cleared, entries are always written before they are read.
module edge_clamped_box_blur_line_unit
  import bbl_pkg::*;
#(
  parameter int MAX_RADIUS = 15
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pixel_in_t pixel,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output result_t   result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [3:0] cfg_data
);

  localparam int HIST = 2 * MAX_RADIUS + 1;
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int NW   = $clog2(HIST);

  logic [3:0]    radius;
  logic          job_valid;
  logic          job_pop;
  job_t          job;
  logic [RW-1:0] job_r;
  logic [NW-1:0] job_n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  bbl_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .push      (push),
    .pixel     (pixel),
    .full      (full),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job),
    .job_r     (job_r),
    .job_n     (job_n)
  );

  bbl_back #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job),
    .job_r     (job_r),
    .job_n     (job_n),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule
